[rtl/tss_pkg.sv]
// Shared types and constants of the throughput sample statistics unit.
// No dependencies; the other files refer to it by scoped names or by a wildcard import.
package tss_pkg;

  // Field widths
  localparam int BYTES_W   = 20;
  localparam int SECONDS_W = 32;
  localparam int SPEED_W   = 40;
  localparam int SEEN_W    = 24;
  localparam int ACC_W     = 40;
  localparam int SUM_W     = 56;
  localparam int MAG_W     = SECONDS_W + 1;

  // Sample counter width (8 to 32)
  localparam int COUNT_BITS = 24;

  // Configuration registers
  localparam int PERIOD_W   = 8;
  localparam int START_W    = 32;
  localparam int AUTOSTOP_W = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_START    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_STOP     = 2'd2;

  localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 8'd1;
  localparam logic [START_W-1:0]    START_RESET    = '0;
  localparam logic [AUTOSTOP_W-1:0] AUTOSTOP_RESET = 16'd60;

  // Shared divider geometry
  localparam int DIVIDEND_W = SUM_W;
  localparam int DIVISOR_W  = 32;
  localparam int STEP_W     = $clog2(DIVIDEND_W + 1);

  localparam logic [STEP_W-1:0] STEPS_MOD   = STEP_W'(MAG_W);
  localparam logic [STEP_W-1:0] STEPS_SPEED = STEP_W'(ACC_W);
  localparam logic [STEP_W-1:0] STEPS_MEAN  = STEP_W'(SUM_W);

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
    logic [STEP_W-1:0]     steps;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MOD_GO,
    S_MOD_WAIT,
    S_SPD_GO,
    S_SPD_WAIT,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_FINISH
  } state_t;

endpackage

[rtl/tss_in_if.sv]
// Request channel carrying one received chunk event.
// Depends on tss_pkg for field widths.
interface tss_in_if;
  logic                           valid;
  logic                           ready;
  logic [tss_pkg::BYTES_W-1:0]    chunk_bytes;
  logic [tss_pkg::SECONDS_W-1:0]  now_seconds;
  logic                           running;

  modport source (output valid, output chunk_bytes, output now_seconds, output running,
                  input ready);
  modport sink   (input valid, input chunk_bytes, input now_seconds, input running,
                  output ready);
endinterface

[rtl/tss_out_if.sv]
// Result channel carrying the per-chunk statistics.
// Depends on tss_pkg for field widths.
interface tss_out_if;
  logic                        valid;
  logic                        ready;
  logic [tss_pkg::BYTES_W-1:0] accepted_bytes;
  logic                        sample_taken;
  logic [tss_pkg::SPEED_W-1:0] max_speed;
  logic [tss_pkg::SPEED_W-1:0] min_speed;
  logic [tss_pkg::SPEED_W-1:0] average_speed;
  logic [tss_pkg::SEEN_W-1:0]  samples_seen;

  modport source (output valid, output accepted_bytes, output sample_taken,
                  output max_speed, output min_speed, output average_speed,
                  output samples_seen, input ready);
  modport sink   (input valid, input accepted_bytes, input sample_taken,
                  input max_speed, input min_speed, input average_speed,
                  input samples_seen, output ready);
endinterface

[rtl/throughput_sample_statistics_unit.sv]
// Top level of the throughput sample statistics unit: sequencer, state and output register.
// Depends on tss_pkg, tss_in_if, tss_out_if and tss_divider.
//
//   channel | direction | handshake     | payload
//   --------+-----------+---------------+----------------------------------------------
//   in_ch   | request   | valid / ready | chunk_bytes, now_seconds, running
//   out_ch  | result    | valid / ready | accepted_bytes, sample_taken, max/min/average
//           |           |               | speed, samples_seen
//   cfg     | write     | cfg_we        | cfg_index, cfg_data
//
// One request at a time. A refused chunk goes from the check state straight to the finish
// state; an accepted chunk that closes no sample runs the period test, a closing sample
// also the speed division, and every sample but the first also the mean division.
// in_ch.ready rises at the edge that loads the result, so the next request can be taken
// in the next cycle. The divisions share one divider, which resolves one quotient bit per
// cycle: 33 bits for the period test, 40 for the speed, 56 for the mean. Reset is synchronous
// and clears all statistics at once. in_ch.ready is high only while the sequencer idles; a
// stalled result waits in the output register while the next request is taken and worked on.
module throughput_sample_statistics_unit (
  input  logic                             clk,
  input  logic                             rst,
  tss_in_if.sink                           in_ch,
  tss_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration
  logic [tss_pkg::PERIOD_W-1:0]   sample_period;
  logic [tss_pkg::START_W-1:0]    test_start_seconds;
  logic [tss_pkg::AUTOSTOP_W-1:0] auto_stop_seconds;

  // Statistics state
  logic [tss_pkg::ACC_W-1:0]      byte_accumulator;
  logic [tss_pkg::SECONDS_W-1:0]  last_record_second;
  logic [tss_pkg::COUNT_BITS-1:0] sample_counter;
  logic [tss_pkg::SPEED_W-1:0]    peak_speed;
  logic [tss_pkg::SPEED_W-1:0]    floor_speed;
  logic [tss_pkg::SUM_W-1:0]      sum_after_first;
  logic [tss_pkg::SPEED_W-1:0]    mean_speed;

  // Latched request and per-item working registers
  logic [tss_pkg::BYTES_W-1:0]    chunk_bytes;
  logic [tss_pkg::SECONDS_W-1:0]  now_seconds;
  logic                           running;
  logic                           accepted;
  logic                           taken;
  logic [tss_pkg::MAG_W-1:0]      mag;

  // Output register
  logic                           out_valid;
  logic [tss_pkg::BYTES_W-1:0]    out_accepted;
  logic                           out_taken;
  logic [tss_pkg::SPEED_W-1:0]    out_max;
  logic [tss_pkg::SPEED_W-1:0]    out_min;
  logic [tss_pkg::SPEED_W-1:0]    out_avg;
  logic [tss_pkg::SEEN_W-1:0]     out_seen;

  tss_pkg::state_t   state, state_next;
  tss_pkg::div_req_t div_req;
  tss_pkg::div_rsp_t div_rsp;

  logic                           in_fire;
  logic                           out_free;
  logic                           chunk_ok;
  logic [tss_pkg::START_W:0]      end_second;
  logic [tss_pkg::MAG_W:0]        elapsed;
  logic [tss_pkg::MAG_W-1:0]      mag_next;
  logic [tss_pkg::ACC_W:0]        acc_sum;
  logic [tss_pkg::ACC_W-1:0]      acc_next;
  logic [tss_pkg::PERIOD_W-1:0]   period;
  logic [tss_pkg::SPEED_W-1:0]    speed;
  logic [tss_pkg::SUM_W:0]        sum_wide;
  logic [tss_pkg::SUM_W-1:0]      sum_next;
  logic [tss_pkg::COUNT_BITS-1:0] count_next;
  logic                           boundary;

  tss_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  // Acceptance test and the signed distance from the start, folded to a magnitude
  always_comb begin
    end_second = {1'b0, test_start_seconds} + (tss_pkg::START_W+1)'(auto_stop_seconds);
    chunk_ok   = running && ({1'b0, now_seconds} < end_second) && (chunk_bytes != '0);
    elapsed    = (tss_pkg::MAG_W+1)'(now_seconds) - (tss_pkg::MAG_W+1)'(test_start_seconds)
                 + (tss_pkg::MAG_W+1)'(1);
    mag_next   = elapsed[tss_pkg::MAG_W] ? (~elapsed[tss_pkg::MAG_W-1:0] + 1'b1)
                                         : elapsed[tss_pkg::MAG_W-1:0];
    acc_sum    = {1'b0, byte_accumulator} + (tss_pkg::ACC_W+1)'(chunk_bytes);
    acc_next   = acc_sum[tss_pkg::ACC_W] ? '1 : acc_sum[tss_pkg::ACC_W-1:0];
    // A zero period acts as one
    period     = (sample_period == '0) ? tss_pkg::PERIOD_W'(1) : sample_period;
    speed      = div_rsp.quotient[tss_pkg::SPEED_W-1:0];
    sum_wide   = {1'b0, sum_after_first} + (tss_pkg::SUM_W+1)'(speed);
    sum_next   = sum_wide[tss_pkg::SUM_W] ? '1 : sum_wide[tss_pkg::SUM_W-1:0];
    count_next = (taken && sample_counter != '1) ? sample_counter + 1'b1 : sample_counter;
    boundary   = (div_rsp.remainder == '0) && (last_record_second != now_seconds);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tss_pkg::S_IDLE:      if (in_fire) state_next = tss_pkg::S_CHECK;
      tss_pkg::S_CHECK:     state_next = chunk_ok ? tss_pkg::S_MOD_GO : tss_pkg::S_FINISH;
      tss_pkg::S_MOD_GO:    state_next = tss_pkg::S_MOD_WAIT;
      tss_pkg::S_MOD_WAIT: begin
        if (div_rsp.done) state_next = boundary ? tss_pkg::S_SPD_GO : tss_pkg::S_FINISH;
      end
      tss_pkg::S_SPD_GO:    state_next = tss_pkg::S_SPD_WAIT;
      tss_pkg::S_SPD_WAIT: begin
        // The first sample skips the mean and leaves the speed statistics as they are
        if (div_rsp.done) begin
          state_next = (sample_counter != '0) ? tss_pkg::S_MEAN_GO : tss_pkg::S_FINISH;
        end
      end
      tss_pkg::S_MEAN_GO:   state_next = tss_pkg::S_MEAN_WAIT;
      tss_pkg::S_MEAN_WAIT: if (div_rsp.done) state_next = tss_pkg::S_FINISH;
      tss_pkg::S_FINISH:    if (out_free) state_next = tss_pkg::S_IDLE;
      default:              state_next = tss_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: request handshake and the divider operands
  always_comb begin
    in_ch.ready      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {mag, (tss_pkg::DIVIDEND_W-tss_pkg::MAG_W)'(0)};
    div_req.divisor  = tss_pkg::DIVISOR_W'(period);
    div_req.steps    = tss_pkg::STEPS_MOD;
    case (state)
      tss_pkg::S_IDLE:    in_ch.ready = 1'b1;
      tss_pkg::S_MOD_GO:  div_req.start = 1'b1;
      tss_pkg::S_SPD_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {byte_accumulator, (tss_pkg::DIVIDEND_W-tss_pkg::ACC_W)'(0)};
        div_req.steps    = tss_pkg::STEPS_SPEED;
      end
      tss_pkg::S_MEAN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = sum_after_first;
        div_req.divisor  = tss_pkg::DIVISOR_W'(sample_counter);
        div_req.steps    = tss_pkg::STEPS_MEAN;
      end
      default: begin
        in_ch.ready   = 1'b0;
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tss_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Configuration writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period      <= tss_pkg::PERIOD_RESET;
      test_start_seconds <= tss_pkg::START_RESET;
      auto_stop_seconds  <= tss_pkg::AUTOSTOP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tss_pkg::CFG_SAMPLE_PERIOD: sample_period      <= cfg_data[tss_pkg::PERIOD_W-1:0];
        tss_pkg::CFG_TEST_START:    test_start_seconds <= cfg_data[tss_pkg::START_W-1:0];
        tss_pkg::CFG_AUTO_STOP:     auto_stop_seconds  <= cfg_data[tss_pkg::AUTOSTOP_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the request; its payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      chunk_bytes <= in_ch.chunk_bytes;
      now_seconds <= in_ch.now_seconds;
      running     <= in_ch.running;
    end
  end

  // Statistics state and per-item flags
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_accumulator   <= '0;
      last_record_second <= '0;
      sample_counter     <= '0;
      peak_speed         <= '0;
      floor_speed        <= '0;
      sum_after_first    <= '0;
      mean_speed         <= '0;
      accepted           <= 1'b0;
      taken              <= 1'b0;
    end else begin
      case (state)
        tss_pkg::S_CHECK: begin
          accepted <= chunk_ok;
          taken    <= 1'b0;
          mag      <= mag_next;
          if (chunk_ok) byte_accumulator <= acc_next;
        end
        tss_pkg::S_SPD_WAIT: begin
          if (div_rsp.done) begin
            taken              <= 1'b1;
            byte_accumulator   <= '0;
            last_record_second <= now_seconds;
            if (sample_counter != '0) begin
              if (peak_speed == '0 || peak_speed < speed) peak_speed <= speed;
              if (floor_speed == '0 || floor_speed > speed) floor_speed <= speed;
              sum_after_first <= sum_next;
            end
          end
        end
        tss_pkg::S_MEAN_WAIT: begin
          if (div_rsp.done) mean_speed <= div_rsp.quotient[tss_pkg::SPEED_W-1:0];
        end
        tss_pkg::S_FINISH: begin
          // Count the sample only once the result is handed to the output register
          if (out_free) sample_counter <= count_next;
        end
        default: ;
      endcase
    end
  end

  // Output register: load on finish, drop once the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tss_pkg::S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tss_pkg::S_FINISH && out_free) begin
      out_accepted <= accepted ? chunk_bytes : '0;
      out_taken    <= taken;
      out_max      <= peak_speed;
      out_min      <= floor_speed;
      out_avg      <= mean_speed;
      out_seen     <= tss_pkg::SEEN_W'(count_next);
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.accepted_bytes = out_accepted;
  assign out_ch.sample_taken   = out_taken;
  assign out_ch.max_speed      = out_max;
  assign out_ch.min_speed      = out_min;
  assign out_ch.average_speed  = out_avg;
  assign out_ch.samples_seen   = out_seen;

endmodule

[rtl/tss_divider.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on tss_pkg (div_req_t, div_rsp_t, widths).
module tss_divider (
  input  logic              clk,
  input  logic              rst,
  input  tss_pkg::div_req_t req,
  output tss_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic [tss_pkg::STEP_W-1:0]     count;
  logic [tss_pkg::DIVISOR_W-1:0]  rem;
  logic [tss_pkg::DIVIDEND_W-1:0] dq;
  logic [tss_pkg::DIVISOR_W-1:0]  dvs;

  logic [tss_pkg::DIVISOR_W:0]    trial;
  logic                           fits;
  logic [tss_pkg::DIVISOR_W:0]    diff;

  // Dividend is left aligned so that only the requested bit count is walked.
  always_comb begin
    trial = {rem, dq[tss_pkg::DIVIDEND_W-1]};
    fits  = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= req.steps;
        rem   <= '0;
        dq    <= req.dividend;
        dvs   <= req.divisor;
      end else if (busy) begin
        rem   <= fits ? diff[tss_pkg::DIVISOR_W-1:0] : trial[tss_pkg::DIVISOR_W-1:0];
        dq    <= {dq[tss_pkg::DIVIDEND_W-2:0], fits};
        count <= count - 1'b1;
        if (count == tss_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = dq;
  assign rsp.remainder = rem;

endmodule

[rtl/tss_checker.sv]
// Port-level checks of the throughput sample statistics unit, bound to the top level.
// Depends on tss_pkg and throughput_sample_statistics_unit.
module tss_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tss_pkg::BYTES_W-1:0] accepted_bytes,
  input logic                        sample_taken,
  input logic [tss_pkg::SPEED_W-1:0] max_speed,
  input logic [tss_pkg::SPEED_W-1:0] min_speed,
  input logic [tss_pkg::SEEN_W-1:0]  samples_seen
);

  // One request in flight: the unit goes busy right after taking one
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is still in work");

  // A refused chunk never closes a sample
  a_refused_no_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted_bytes == '0 |-> !sample_taken)
    else $error("sample closed by a refused chunk");

  // The minimum never exceeds the maximum
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> min_speed <= max_speed)
    else $error("minimum speed above maximum speed");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(samples_seen) && $stable(max_speed))
    else $error("stalled result changed or dropped");

endmodule

bind throughput_sample_statistics_unit tss_checker u_tss_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .accepted_bytes (out_ch.accepted_bytes),
  .sample_taken   (out_ch.sample_taken),
  .max_speed      (out_ch.max_speed),
  .min_speed      (out_ch.min_speed),
  .samples_seen   (out_ch.samples_seen)
);

[test/tss_stats_checker.sv]
`timescale 1ns / 1ps
// Checker for the throughput sample statistics unit: mirrors the register writes,
// predicts one statistics record per chunk request and compares it with the result channel.
// Depends on tss_pkg, tss_in_if and tss_out_if.
module tss_stats_checker (
  input  logic                           clk,
  input  logic                           rst,
  tss_in_if                              in_ch,
  tss_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending
);
  import tss_pkg::*;

  localparam logic [63:0] ACC_TOP   = (64'd1 << ACC_W) - 1;
  localparam logic [63:0] SUM_TOP   = (64'd1 << SUM_W) - 1;
  localparam logic [63:0] SPEED_TOP = (64'd1 << SPEED_W) - 1;
  localparam logic [63:0] COUNT_TOP = (64'd1 << COUNT_BITS) - 1;

  typedef struct packed {
    logic [BYTES_W-1:0] accepted_bytes;
    logic               sample_taken;
    logic [SPEED_W-1:0] max_speed;
    logic [SPEED_W-1:0] min_speed;
    logic [SPEED_W-1:0] average_speed;
    logic [SEEN_W-1:0]  samples_seen;
  } stats_rec_t;

  // Register mirror
  logic [PERIOD_W-1:0]   period_reg;
  logic [START_W-1:0]    start_reg;
  logic [AUTOSTOP_W-1:0] stop_len_reg;

  // Statistics state, held wide so saturation is checked before it is applied
  logic [63:0] acc_bytes, last_sec, n_samples, speed_hi, speed_lo, speed_sum, speed_mean;

  stats_rec_t stats_due_q[$];

  function automatic stats_rec_t advance_stats(input logic [BYTES_W-1:0]   b,
                                               input logic [SECONDS_W-1:0] s,
                                               input logic                 r);
    stats_rec_t  rec;
    logic [63:0] per, stop_at, mag, spd;
    longint      offs;
    rec     = '0;
    per     = (period_reg == '0) ? 64'd1 : 64'(period_reg);
    stop_at = 64'(start_reg) + 64'(stop_len_reg);
    if (r && 64'(s) < stop_at && b != '0) begin
      rec.accepted_bytes = b;
      offs = longint'({32'd0, s}) - longint'({32'd0, start_reg}) + 1;
      mag  = (offs < 0) ? 64'(-offs) : 64'(offs);
      acc_bytes = acc_bytes + 64'(b);
      if (acc_bytes > ACC_TOP) acc_bytes = ACC_TOP;
      if ((mag % per) == 0 && last_sec != 64'(s)) begin
        spd = acc_bytes / per;
        rec.sample_taken = 1'b1;
        // the first sample after reset primes the counter but updates no speed statistics
        if (n_samples != 0) begin
          if (speed_hi == 0 || speed_hi < spd) speed_hi = spd;
          if (speed_lo == 0 || speed_lo > spd) speed_lo = spd;
          speed_sum = speed_sum + spd;
          if (speed_sum > SUM_TOP) speed_sum = SUM_TOP;
          speed_mean = (speed_sum / n_samples) & SPEED_TOP;
        end
        if (n_samples < COUNT_TOP) n_samples = n_samples + 1;
        acc_bytes = 0;
        last_sec  = 64'(s);
      end
    end
    rec.max_speed     = speed_hi[SPEED_W-1:0];
    rec.min_speed     = speed_lo[SPEED_W-1:0];
    rec.average_speed = speed_mean[SPEED_W-1:0];
    rec.samples_seen  = n_samples[SEEN_W-1:0];
    return rec;
  endfunction

  task automatic note_fault(input string what, input stats_rec_t want, input stats_rec_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected bytes=%0d taken=%0d max=%0d min=%0d avg=%0d seen=%0d",
               $time, what, want.accepted_bytes, want.sample_taken, want.max_speed,
               want.min_speed, want.average_speed, want.samples_seen,
               "\n    got bytes=%0d taken=%0d max=%0d min=%0d avg=%0d seen=%0d",
               got.accepted_bytes, got.sample_taken, got.max_speed, got.min_speed,
               got.average_speed, got.samples_seen);
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    stats_rec_t got;
    if (rst) begin
      period_reg   = PERIOD_RESET;
      start_reg    = START_RESET;
      stop_len_reg = AUTOSTOP_RESET;
      acc_bytes    = 0;
      last_sec     = 0;
      n_samples    = 0;
      speed_hi     = 0;
      speed_lo     = 0;
      speed_sum    = 0;
      speed_mean   = 0;
      stats_due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_PERIOD: period_reg   = cfg_data[PERIOD_W-1:0];
          CFG_TEST_START:    start_reg    = cfg_data[START_W-1:0];
          CFG_AUTO_STOP:     stop_len_reg = cfg_data[AUTOSTOP_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        stats_due_q = {stats_due_q, advance_stats(in_ch.chunk_bytes, in_ch.now_seconds,
                                                  in_ch.running)};
      if (out_ch.valid && out_ch.ready) begin
        got.accepted_bytes = out_ch.accepted_bytes;
        got.sample_taken   = out_ch.sample_taken;
        got.max_speed      = out_ch.max_speed;
        got.min_speed      = out_ch.min_speed;
        got.average_speed  = out_ch.average_speed;
        got.samples_seen   = out_ch.samples_seen;
        if (stats_due_q.size() == 0)
          note_fault("unexpected result", '0, got);
        else if (got !== stats_due_q[0]) begin
          note_fault("result mismatch", stats_due_q[0], got);
          void'(stats_due_q.pop_front());
        end else
          void'(stats_due_q.pop_front());
      end
    end
    pending = stats_due_q.size();
  end

endmodule

[test/tb_throughput_sample_statistics_unit.sv]
`timescale 1ns / 1ps
// Testbench top for the throughput sample statistics unit: clock, reset, chunk requests,
// register writes, result back-pressure and the verdict.
// Depends on tss_pkg, tss_in_if, tss_out_if, the unit itself and tss_stats_checker.
module tb_throughput_sample_statistics_unit;
  import tss_pkg::*;

  localparam int ITEM_TARGET = 1750;
  localparam int HOLD_CYCLES = 600;   // long receiver hold-off, well past one request
  localparam int STALL_LIMIT = 6000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES = 200;

  // Receiver stall patterns
  typedef enum int {FLOW_OPEN, FLOW_COIN, FLOW_TRICKLE} flow_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;

  tss_in_if  in_ch();
  tss_out_if out_ch();

  throughput_sample_statistics_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tss_stats_checker stats_mon (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (errors),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // Receiver: a long hold-off whenever the stimulus asks for one, otherwise a random stall
  // pattern that is picked anew whenever the last one runs out. hold_asks is bumped with a
  // nonblocking write, so the receiver sees the request without a race.
  int    hold_asks = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  int    flow_left = 0;
  flow_t flow      = FLOW_OPEN;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      if (flow_left == 0) begin
        flow      = flow_t'($urandom_range(0, 2));
        flow_left = $urandom_range(20, 200);
      end
      flow_left--;
      case (flow)
        FLOW_OPEN: out_ch.ready <= 1'b1;
        FLOW_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
        default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog: count cycles in which neither channel completes a handshake.
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Sender state: requests go out in bursts, with idle gaps between most bursts.
  int burst_left = 0;
  int sent       = 0;

  // Offer one chunk request and return at the edge that accepts it. Called at a
  // rising edge; valid is either raised with the new payload or dropped for a gap,
  // never both in one step.
  task automatic offer_chunk(input logic [BYTES_W-1:0]   b,
                             input logic [SECONDS_W-1:0] s,
                             input logic                 r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 20);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.chunk_bytes <= b;
    in_ch.now_seconds <= s;
    in_ch.running     <= r;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // Drop valid and hold until every predicted result has been taken, so the
  // unit is idle before registers change. Wait for the next edge first so the checker
  // has queued the request accepted at the current edge.
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_regs(input logic [PERIOD_W-1:0]   per,
                          input logic [START_W-1:0]    st,
                          input logic [AUTOSTOP_W-1:0] len);
    write_reg(CFG_SAMPLE_PERIOD, CFG_DATA_W'(per));
    write_reg(CFG_TEST_START, CFG_DATA_W'(st));
    write_reg(CFG_AUTO_STOP, CFG_DATA_W'(len));
  endtask

  initial begin
    logic [PERIOD_W-1:0]   per;
    logic [START_W-1:0]    st;
    logic [AUTOSTOP_W-1:0] len;
    logic [SECONDS_W-1:0]  sec;
    logic [BYTES_W-1:0]    b;
    int                    span;
    int                    sess;

    // Drive every input to a known value before the first edge.
    in_ch.valid       = 1'b0;
    in_ch.chunk_bytes = '0;
    in_ch.now_seconds = '0;
    in_ch.running     = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset registers: one-second period, start at
    // zero, sixty seconds of test.
    offer_chunk('0, 32'd5, 1'b1);              // zero bytes: refuse
    offer_chunk(20'd100, 32'd5, 1'b0);         // stopped: refuse
    offer_chunk(20'd100, 32'd60, 1'b1);        // at start plus auto-stop: refuse
    offer_chunk(20'hFFFFF, 32'd0, 1'b1);       // boundary but same second as last record
    offer_chunk(20'd1000, 32'd1, 1'b1);        // first sample, dropped from statistics
    offer_chunk(20'd1000, 32'd1, 1'b1);        // same second again: no sample
    offer_chunk(20'd50000, 32'd2, 1'b1);       // first counted sample
    offer_chunk(20'd10, 32'd3, 1'b1);          // lower sample: new minimum
    offer_chunk(20'hFFFFF, 32'd59, 1'b1);      // last second of the test: new maximum
    offer_chunk(20'hFFFFF, 32'hFFFFFFFF, 1'b1); // far past the end: refuse

    // Widest period, start ahead of the chunks, longest test.
    settle();
    set_regs(8'd255, 32'd1000, 16'hFFFF);
    offer_chunk(20'd3, 32'd744, 1'b1);         // before start, |elapsed+1| = 255: sample
    offer_chunk(20'd1, 32'd900, 1'b1);
    offer_chunk(20'd1, 32'd1254, 1'b1);        // speed rounds to zero: minimum unset again
    offer_chunk(20'hFFFFF, 32'd1509, 1'b1);
    offer_chunk(20'd77, 32'd1764, 1'b1);

    // Zero period acts as one; start at the top of the second counter.
    settle();
    set_regs(8'd0, 32'hFFFFFFFF, 16'hFFFF);
    offer_chunk(20'hFFFFF, 32'hFFFFFFFF, 1'b1);
    offer_chunk(20'd7, 32'd0, 1'b1);           // far before start
    offer_chunk(20'd3, 32'hFFFFFFFE, 1'b1);    // elapsed+1 is zero

    // Zero-length test: everything is refused.
    settle();
    set_regs(8'd1, 32'd0, 16'd0);
    offer_chunk(20'd5, 32'd0, 1'b1);
    offer_chunk(20'h55555, 32'hAAAAAAAA, 1'b1);

    // Random sessions: set registers while idle, then a run of chunks whose
    // seconds advance the way a live test does, with some noise mixed in.
    sess = 0;
    while (sent < ITEM_TARGET) begin
      settle();
      case ($urandom_range(0, 9))
        0:       per = 8'd0;
        1:       per = 8'd255;
        2:       per = 8'($urandom_range(1, 255));
        default: per = 8'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 7))
        0:       st = '0;
        1:       st = 32'hFFFFFFFF - 32'($urandom_range(0, 40));
        2:       st = $urandom();
        default: st = 32'($urandom_range(100, 100000));
      endcase
      case ($urandom_range(0, 7))
        0:       len = '0;
        1:       len = 16'hFFFF;
        2:       len = 16'($urandom_range(0, 65535));
        default: len = 16'($urandom_range(10, 400));
      endcase
      set_regs(per, st, len);

      // Now and then stall the result side for a long stretch while requests
      // keep coming, so the unit backs up into its input.
      if (sess % 9 == 3) hold_asks <= hold_asks + 1;

      span = $urandom_range(20, 90);
      sec  = st - 32'($urandom_range(0, 8));
      repeat (span) begin
        case ($urandom_range(0, 5))
          0:       sec = sec + 32'd2;
          1, 2:    ;
          default: sec = sec + 32'd1;
        endcase
        case ($urandom_range(0, 4))
          0:       b = 20'hFFFFF;
          1:       b = 20'd1;
          2:       b = 20'($urandom_range(1, 255));
          default: b = 20'($urandom_range(1, 20'hFFFFF));
        endcase
        case ($urandom_range(0, 19))
          0:       offer_chunk(20'($urandom()), $urandom(), 1'($urandom_range(0, 1)));
          1:       offer_chunk('0, sec, 1'b1);
          2:       offer_chunk(b, sec, 1'b0);
          default: offer_chunk(b, sec, 1'b1);
        endcase
      end
      sess++;
    end

    // Drain, then give the unit time to show any stray result.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[throughput_sample_statistics_unit.f]
rtl/tss_pkg.sv
rtl/tss_in_if.sv
rtl/tss_out_if.sv
rtl/tss_divider.sv
rtl/throughput_sample_statistics_unit.sv
rtl/tss_checker.sv
test/tss_stats_checker.sv
test/tb_throughput_sample_statistics_unit.sv
